### rtl/next_fit_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// next_fit_block_allocator_defines
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define NFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NFBA_ASSERT(lbl, prop, msg)
`define NFBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Constants, codes and control types of the next-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package nfba_pkg;

  localparam int NUM_SUBHEAPS  = 4;
  localparam int SUBHEAP_WORDS = 1024;
  localparam int WORD_BYTES    = 8;

  localparam int SLOT_W   = $clog2(NUM_SUBHEAPS);
  localparam int IDX_W    = $clog2(SUBHEAP_WORDS);
  localparam int LINK_W   = IDX_W + 1;
  localparam int ADDR_W   = SLOT_W + IDX_W;
  localparam int MW       = $clog2(SUBHEAP_WORDS + 1);
  localparam int CLEN_W   = $clog2(NUM_SUBHEAPS + 1);
  localparam int WALK_LIMIT = 4 * SUBHEAP_WORDS + 4;
  localparam int STEP_W   = $clog2(WALK_LIMIT + 1);
  localparam int WB_SHIFT = $clog2(WORD_BYTES);

  localparam int EB_W    = 13;
  localparam int EPS_W   = 16;
  localparam int CNT_W   = 16;
  localparam int FSLOT_W = 2;
  localparam int OFF_W   = 10;
  localparam int ST_W    = 3;
  localparam int PROD_W  = EB_W + EPS_W;
  localparam int GEO_W   = PROD_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 16;

  localparam logic [EB_W-1:0]  EB_RESET  = 13'd8;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1000;

  localparam logic CFG_EB  = 1'b0;
  localparam logic CFG_EPS = 1'b1;

  localparam logic FUNC_ALLOC = 1'b0;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_SLOT   = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_FREE  = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_CFG   = 3'd4;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_MUL,
    OP_GEOM,
    OP_RESULT,
    OP_FREE_RD,
    OP_FREE_WR,
    OP_SCAN_NEXT,
    OP_WALK_INIT,
    OP_W_RD,
    OP_W_V,
    OP_M_RD,
    OP_M_MERGE,
    OP_M_END,
    OP_W_NXT,
    OP_W_NV,
    OP_ACT,
    OP_ACT2,
    OP_SPLIT_RD,
    OP_SPLIT_WR,
    OP_SPLIT_FIN
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ST_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic too_large;
    logic oversize;
    logic free_bad;
    logic scan_end;
    logic scan_fit;
    logic no_slot;
    logic step_limit;
    logic rd_used;
    logic merge_limit;
    logic fit;
    logic wrap;
    logic loops;
  } stat_t;

endpackage
`default_nettype wire

### rtl/nfba_dp.sv
// ----------------------------------------------------------------------------
// nfba_dp
// Datapath: config registers, geometry, slot tables, link memory, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "next_fit_block_allocator_defines.svh"
module nfba_dp (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_fire,
  input  wire                                 in_func,
  input  wire  [nfba_pkg::IN_DATA_W-1:0]      in_data,
  input  wire                                 cfg_fire,
  input  wire                                 cfg_idx,
  input  wire  [nfba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire                                 out_fire,
  input  nfba_pkg::cmd_t                      cmd,
  output nfba_pkg::stat_t                     stat,
  output logic                                out_valid,
  output logic [nfba_pkg::ST_W-1:0]           out_status,
  output logic [nfba_pkg::FSLOT_W-1:0]        out_slot,
  output logic [nfba_pkg::OFF_W-1:0]          out_off
);

  localparam int NS = nfba_pkg::NUM_SUBHEAPS;
  localparam int SW = nfba_pkg::SLOT_W;
  localparam int IW = nfba_pkg::IDX_W;
  localparam int LW = nfba_pkg::LINK_W;
  localparam int MW = nfba_pkg::MW;
  localparam int CW = nfba_pkg::CLEN_W;

  logic [nfba_pkg::EB_W-1:0]    eb_r;
  logic [nfba_pkg::EPS_W-1:0]   eps_r;
  logic                         func_r;
  logic [nfba_pkg::CNT_W-1:0]   cnt_r;
  logic [SW-1:0]                fs_r;
  logic [nfba_pkg::OFF_W-1:0]   foff_r;
  logic [nfba_pkg::PROD_W-1:0]  prod_m_r;
  logic [nfba_pkg::PROD_W-1:0]  prod_w_r;
  logic [MW-1:0]                m_r;
  logic [MW-1:0]                nw_r;
  logic                         too_large_r;
  logic                         oversize_r;
  logic [CW-1:0]                k_r;
  logic [SW-1:0]                s_r;
  logic [IW-1:0]                cur_r;
  logic [IW-1:0]                nxt_r;
  logic [LW-1:0]                cl_r;
  logic                         loops_r;
  logic [nfba_pkg::STEP_W-1:0]  steps_r;
  logic [MW-1:0]                mcnt_r;
  logic [LW-1:0]                rd_r;
  logic [MW-1:0]                fcnt_r  [NS];
  logic [IW-1:0]                ss_r    [NS];
  logic [NS-1:0]                active_r;
  logic [SW-1:0]                order_r [NS];
  logic [CW-1:0]                clen_r;

  logic [LW-1:0] mem [NS * nfba_pkg::SUBHEAP_WORDS];

  logic                          mem_we;
  logic [nfba_pkg::ADDR_W-1:0]   mem_waddr;
  logic [LW-1:0]                 mem_wdata;
  logic                          mem_re;
  logic [nfba_pkg::ADDR_W-1:0]   mem_raddr;

  logic [nfba_pkg::PROD_W:0]     m_sum;
  logic [nfba_pkg::PROD_W:0]     w_sum;
  logic [nfba_pkg::GEO_W-1:0]    m_full;
  logic [nfba_pkg::GEO_W-1:0]    w_full;
  logic [SW-1:0]                 scan_slot;
  logic                          in_chain;
  logic [CW-1:0]                 pos;
  logic [SW-1:0]                 act_slot;
  logic                          none_free;
  logic [IW-1:0]                 ctl;
  logic [IW-1:0]                 credit;
  logic [MW:0]                   csum;
  logic [MW-1:0]                 cnew;
  logic                          unlink;
  logic [MW:0]                   sp;
  logic [MW-1:0]                 m_less;
  logic [SW-1:0]                 order_sh [NS];

  assign m_sum  = {1'b0, prod_m_r} + (nfba_pkg::PROD_W+1)'(nfba_pkg::WORD_BYTES - 1);
  assign w_sum  = {1'b0, prod_w_r} + (nfba_pkg::PROD_W+1)'(nfba_pkg::WORD_BYTES - 1);
  assign m_full = nfba_pkg::GEO_W'(m_sum >> nfba_pkg::WB_SHIFT) + nfba_pkg::GEO_W'(2);
  assign w_full = nfba_pkg::GEO_W'(w_sum >> nfba_pkg::WB_SHIFT) + nfba_pkg::GEO_W'(1);
  assign m_less = m_r - MW'(1);

  assign scan_slot = order_r[k_r[SW-1:0]];
  assign ctl       = foff_r - IW'(1);
  assign sp        = (MW+1)'(cur_r) + (MW+1)'(nw_r);

  always_comb begin
    in_chain = 1'b0;
    pos      = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if ((CW'(i) < clen_r) && (order_r[i] == fs_r)) begin
        in_chain = 1'b1;
        pos      = CW'(i);
      end
    end
  end

  always_comb begin
    none_free = 1'b1;
    act_slot  = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        none_free = 1'b0;
        act_slot  = SW'(i);
      end
    end
  end

  always_comb begin
    credit = (rd_r[LW-1:1] > ctl) ? (rd_r[LW-1:1] - ctl) : '0;
    csum   = (MW+1)'(fcnt_r[fs_r]) + (MW+1)'(credit);
    cnew   = (csum > (MW+1)'(m_less)) ? m_less : csum[MW-1:0];
    unlink = (pos != '0) && (cnew == m_less);
    for (int i = 0; i < NS; i++) begin
      order_sh[i] = order_r[i];
      if ((CW'(i) >= pos) && ((CW'(i) + CW'(1)) < clen_r)) begin
        order_sh[i] = order_r[(i + 1) % NS];
      end
      if ((CW'(i) + CW'(1)) == clen_r) begin
        order_sh[i] = '0;
      end
    end
  end

  always_comb begin
    stat.func        = func_r;
    stat.too_large   = too_large_r;
    stat.oversize    = oversize_r;
    stat.free_bad    = (foff_r == '0) || !active_r[fs_r] ||
                       ((MW)'(foff_r) >= m_r) || !in_chain;
    stat.scan_end    = (k_r >= clen_r);
    stat.scan_fit    = (fcnt_r[scan_slot] >= nw_r);
    stat.no_slot     = none_free || (clen_r >= CW'(NS));
    stat.step_limit  = (steps_r >= nfba_pkg::STEP_W'(nfba_pkg::WALK_LIMIT));
    stat.rd_used     = rd_r[0];
    stat.merge_limit = (mcnt_r >= MW'(nfba_pkg::SUBHEAP_WORDS));
    stat.fit         = ((MW+1)'(nxt_r) >= sp);
    stat.wrap        = (nxt_r > rd_r[LW-1:1]);
    stat.loops       = loops_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {s_r, cur_r};
    mem_wdata = rd_r;
    mem_re    = 1'b0;
    mem_raddr = {s_r, cur_r};
    unique case (cmd.op)
      nfba_pkg::OP_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {fs_r, ctl};
      end
      nfba_pkg::OP_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {fs_r, ctl};
        mem_wdata = {rd_r[LW-1:1], 1'b0};
      end
      nfba_pkg::OP_W_RD, nfba_pkg::OP_SPLIT_RD: begin
        mem_re = 1'b1;
      end
      nfba_pkg::OP_M_RD, nfba_pkg::OP_W_NXT: begin
        mem_re    = 1'b1;
        mem_raddr = {s_r, nxt_r};
      end
      nfba_pkg::OP_M_MERGE: begin
        mem_we = 1'b1;
      end
      nfba_pkg::OP_ACT: begin
        mem_we    = 1'b1;
        mem_waddr = {act_slot, IW'(0)};
        mem_wdata = {m_less[IW-1:0], 1'b0};
      end
      nfba_pkg::OP_ACT2: begin
        mem_we    = 1'b1;
        mem_waddr = {s_r, m_less[IW-1:0]};
        mem_wdata = LW'(1);
      end
      nfba_pkg::OP_SPLIT_WR: begin
        mem_we    = (MW+1)'(nxt_r) > sp;
        mem_waddr = {s_r, sp[IW-1:0]};
      end
      nfba_pkg::OP_SPLIT_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = {sp[IW-1:0], 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      cnt_r  <= in_data[15:0];
      fs_r   <= in_data[17:16];
      foff_r <= in_data[27:18];
    end
    unique case (cmd.op)
      nfba_pkg::OP_MUL: begin
        prod_m_r <= eb_r * eps_r;
        prod_w_r <= nfba_pkg::PROD_W'(cnt_r * eb_r);
      end
      nfba_pkg::OP_GEOM: begin
        m_r         <= m_full[MW-1:0];
        nw_r        <= w_full[MW-1:0];
        too_large_r <= m_full > nfba_pkg::GEO_W'(nfba_pkg::SUBHEAP_WORDS);
        oversize_r  <= w_full > (m_full - nfba_pkg::GEO_W'(1));
      end
      nfba_pkg::OP_WALK_INIT: begin
        s_r     <= scan_slot;
        cur_r   <= ss_r[scan_slot];
        loops_r <= 1'b0;
        steps_r <= '0;
      end
      nfba_pkg::OP_W_V: begin
        nxt_r  <= rd_r[0] ? cur_r : rd_r[LW-1:1];
        cl_r   <= rd_r;
        mcnt_r <= '0;
      end
      nfba_pkg::OP_M_MERGE: begin
        cl_r   <= rd_r;
        nxt_r  <= rd_r[LW-1:1];
        mcnt_r <= mcnt_r + MW'(1);
      end
      nfba_pkg::OP_W_NV: begin
        if (stat.wrap) begin
          loops_r <= 1'b1;
        end
        cur_r   <= rd_r[LW-1:1];
        steps_r <= steps_r + nfba_pkg::STEP_W'(1);
      end
      nfba_pkg::OP_ACT: begin
        s_r   <= act_slot;
        cur_r <= '0;
        nxt_r <= m_less[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_r      <= nfba_pkg::EB_RESET;
      eps_r     <= nfba_pkg::EPS_RESET;
      active_r  <= '0;
      clen_r    <= '0;
      k_r       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        fcnt_r[i]  <= '0;
        ss_r[i]    <= '0;
        order_r[i] <= '0;
      end
    end else begin
      if (cfg_fire) begin
        if (cfg_idx == nfba_pkg::CFG_EB) begin
          eb_r <= cfg_wdata[nfba_pkg::EB_W-1:0];
        end else begin
          eps_r <= cfg_wdata;
        end
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        nfba_pkg::OP_GEOM: begin
          k_r <= '0;
        end
        nfba_pkg::OP_RESULT: begin
          out_valid  <= 1'b1;
          out_status <= cmd.code;
          out_slot   <= '0;
          out_off    <= '0;
        end
        nfba_pkg::OP_FREE_RD: begin
          ss_r[fs_r] <= ctl;
        end
        nfba_pkg::OP_FREE_WR: begin
          fcnt_r[fs_r] <= cnew;
          if (unlink) begin
            for (int i = 0; i < NS; i++) begin
              order_r[i] <= order_sh[i];
            end
            clen_r         <= clen_r - CW'(1);
            active_r[fs_r] <= 1'b0;
          end
        end
        nfba_pkg::OP_SCAN_NEXT: begin
          k_r <= k_r + CW'(1);
        end
        nfba_pkg::OP_M_END: begin
          if ((cur_r < ss_r[s_r]) && (ss_r[s_r] < cl_r[LW-1:1])) begin
            ss_r[s_r] <= cur_r;
          end
        end
        nfba_pkg::OP_ACT: begin
          active_r[act_slot]          <= 1'b1;
          order_r[clen_r[SW-1:0]]     <= act_slot;
          clen_r                      <= clen_r + CW'(1);
          fcnt_r[act_slot]            <= m_less;
          ss_r[act_slot]              <= '0;
        end
        nfba_pkg::OP_SPLIT_RD: begin
          ss_r[s_r] <= sp[IW-1:0];
        end
        nfba_pkg::OP_SPLIT_FIN: begin
          fcnt_r[s_r] <= fcnt_r[s_r] - nw_r;
          out_valid   <= 1'b1;
          out_status  <= nfba_pkg::ST_OK;
          out_slot    <= s_r;
          out_off     <= nfba_pkg::OFF_W'(cur_r) + nfba_pkg::OFF_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  `NFBA_ASSERT(a_clen_range, clen_r <= CW'(NS), "chain longer than slot count")
  `NFBA_ASSERT(a_active_count, $countones(active_r) == int'(clen_r), "active set and chain disagree")
  `NFBA_ASSERT(a_step_bound, !(cmd.op == nfba_pkg::OP_W_NV && stat.step_limit), "walk overrun")
  `NFBA_ASSERT_NEXT(a_act_grows, cmd.op == nfba_pkg::OP_ACT, clen_r == $past(clen_r) + CW'(1), "activation lost")

endmodule
`default_nettype wire

### rtl/nfba_ctrl.sv
// ----------------------------------------------------------------------------
// nfba_ctrl
// Controller: sequences geometry, free, chain scan, next-fit walk and split.
// ----------------------------------------------------------------------------
`default_nettype none
`include "next_fit_block_allocator_defines.svh"
module nfba_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_fire,
  input  nfba_pkg::stat_t  stat,
  output nfba_pkg::cmd_t   cmd,
  output logic             idle
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_GEOM, S_CHECK, S_FREE_RD, S_FREE_WR, S_SCAN, S_WALK_INIT,
    S_W_CHK, S_W_V, S_M_RD, S_M_CHK, S_M_END, S_W_FIT, S_W_NV, S_ACT, S_ACT2,
    S_SPLIT_RD, S_SPLIT_WR, S_SPLIT_FIN, S_RESULT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [nfba_pkg::ST_W-1:0]     code_r, code_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = nfba_pkg::OP_NOP;
    cmd.code  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = nfba_pkg::OP_MUL;
        state_nxt = S_GEOM;
      end
      S_GEOM: begin
        cmd.op    = nfba_pkg::OP_GEOM;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.too_large) begin
          code_nxt  = nfba_pkg::ST_BAD_CFG;
          state_nxt = S_RESULT;
        end else if (stat.func != nfba_pkg::FUNC_ALLOC) begin
          if (stat.free_bad) begin
            code_nxt  = nfba_pkg::ST_BAD_FREE;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_FREE_RD;
          end
        end else if (stat.oversize) begin
          code_nxt  = nfba_pkg::ST_TOO_LARGE;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FREE_RD: begin
        cmd.op    = nfba_pkg::OP_FREE_RD;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.op    = nfba_pkg::OP_FREE_WR;
        code_nxt  = nfba_pkg::ST_OK;
        state_nxt = S_RESULT;
      end
      S_SCAN: begin
        priority if (stat.scan_end) begin
          if (stat.no_slot) begin
            code_nxt  = nfba_pkg::ST_NO_SLOT;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_ACT;
          end
        end else if (stat.scan_fit) begin
          state_nxt = S_WALK_INIT;
        end else begin
          cmd.op = nfba_pkg::OP_SCAN_NEXT;
        end
      end
      S_WALK_INIT: begin
        cmd.op    = nfba_pkg::OP_WALK_INIT;
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (stat.step_limit) begin
          cmd.op    = nfba_pkg::OP_SCAN_NEXT;
          state_nxt = S_SCAN;
        end else begin
          cmd.op    = nfba_pkg::OP_W_RD;
          state_nxt = S_W_V;
        end
      end
      S_W_V: begin
        cmd.op    = nfba_pkg::OP_W_V;
        state_nxt = stat.rd_used ? S_W_FIT : S_M_RD;
      end
      S_M_RD: begin
        if (stat.merge_limit) begin
          state_nxt = S_M_END;
        end else begin
          cmd.op    = nfba_pkg::OP_M_RD;
          state_nxt = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if (!stat.rd_used) begin
          cmd.op    = nfba_pkg::OP_M_MERGE;
          state_nxt = S_M_RD;
        end else begin
          state_nxt = S_M_END;
        end
      end
      S_M_END: begin
        cmd.op    = nfba_pkg::OP_M_END;
        state_nxt = S_W_FIT;
      end
      S_W_FIT: begin
        if (stat.fit) begin
          state_nxt = S_SPLIT_RD;
        end else begin
          cmd.op    = nfba_pkg::OP_W_NXT;
          state_nxt = S_W_NV;
        end
      end
      S_W_NV: begin
        if (stat.wrap && stat.loops) begin
          cmd.op    = nfba_pkg::OP_SCAN_NEXT;
          state_nxt = S_SCAN;
        end else begin
          cmd.op    = nfba_pkg::OP_W_NV;
          state_nxt = S_W_CHK;
        end
      end
      S_ACT: begin
        cmd.op    = nfba_pkg::OP_ACT;
        state_nxt = S_ACT2;
      end
      S_ACT2: begin
        cmd.op    = nfba_pkg::OP_ACT2;
        state_nxt = S_SPLIT_RD;
      end
      S_SPLIT_RD: begin
        cmd.op    = nfba_pkg::OP_SPLIT_RD;
        state_nxt = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        cmd.op    = nfba_pkg::OP_SPLIT_WR;
        state_nxt = S_SPLIT_FIN;
      end
      S_SPLIT_FIN: begin
        cmd.op    = nfba_pkg::OP_SPLIT_FIN;
        state_nxt = S_IDLE;
      end
      S_RESULT: begin
        cmd.op    = nfba_pkg::OP_RESULT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= nfba_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  `NFBA_ASSERT(a_fire_idle, !in_fire || (state_r == S_IDLE), "item taken while busy")
  `NFBA_ASSERT_NEXT(a_split_done, state_r == S_SPLIT_FIN, state_r == S_IDLE, "split did not finish")
  `NFBA_ASSERT_NEXT(a_result_done, state_r == S_RESULT, state_r == S_IDLE, "result did not finish")

endmodule
`default_nettype wire

### rtl/next_fit_block_allocator.sv
// Timing depends on the path: a config, size or free error, a free, or an
// allocation into a new slot or into a free block at the search pointer, with
// extra work per skipped subheap, per used and free block stepped over and per
// merged block; the single link-memory read port paces the walk. One item in
// flight: the next word is taken from the cycle after the result word has left.
// Sync active-low reset clears tables and chain and restores config defaults.
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator over fixed subheap slots with boundary-tag links.
// ----------------------------------------------------------------------------
`default_nettype none
module next_fit_block_allocator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [15:0] elem_count, [17:16] free_subheap, [27:18] free_offset
  input  wire  [nfba_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] func
  input  wire                                 in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [1:0] out_subheap, [11:2] out_offset
  output logic [nfba_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [nfba_pkg::ST_W-1:0]           out_tuser,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire                                 cfg_index,
  input  wire  [nfba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  nfba_pkg::cmd_t                 cmd;
  nfba_pkg::stat_t                stat;
  logic                           idle;
  logic                           in_fire;
  logic                           out_fire;
  logic [nfba_pkg::FSLOT_W-1:0]   res_slot;
  logic [nfba_pkg::OFF_W-1:0]     res_off;

  assign in_tready = idle && !out_tvalid;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign out_tdata = {4'b0, res_off, res_slot};

  nfba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle)
  );

  nfba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_func    (in_tuser),
    .in_data    (in_tdata),
    .cfg_fire   (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_fire   (out_fire),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_slot   (res_slot),
    .out_off    (res_off)
  );

endmodule
`default_nettype wire

### sim/tb_next_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_next_fit_block_allocator
// Stream testbench of the next-fit block allocator. A behavioral copy of the
// slot tables and link store predicts each result word, and a checker
// compares every result word with the oldest prediction. The run goes
// through several geometries, the extremes and oversized ones among them.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_next_fit_block_allocator;

  localparam logic FUNC_FREE = 1'b1;
  localparam int NS = nfba_pkg::NUM_SUBHEAPS;
  localparam int SHW = nfba_pkg::SUBHEAP_WORDS;
  localparam int WB = nfba_pkg::WORD_BYTES;

  typedef struct packed {
    logic [nfba_pkg::ST_W-1:0]    st;
    logic [nfba_pkg::FSLOT_W-1:0] sh;
    logic [nfba_pkg::OFF_W-1:0]   off;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [nfba_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [nfba_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  wire in_tready, out_tvalid, cfg_ready;
  wire [nfba_pkg::OUT_DATA_W-1:0] out_tdata;
  wire [nfba_pkg::ST_W-1:0] out_tuser;

  next_fit_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // allocator shadow state
  int unsigned link_mem [NS][SHW];
  bit          link_set [NS][SHW];
  int unsigned free_words [NS];
  int unsigned fit_start [NS];
  bit          slot_on [NS];
  int unsigned slot_chain [NS];
  int unsigned chain_len;
  int unsigned elem_bytes_r = 8;
  int unsigned elem_per_heap_r = 1000;

  alloc_result_t result_q[$];
  logic [11:0]   live_q[$];
  int errors = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned heap_words();
    return 2 + (longint'(elem_bytes_r) * elem_per_heap_r + WB - 1) / WB;
  endfunction

  function automatic void link_wr(int unsigned s, int unsigned i, int unsigned v);
    link_mem[s][i % SHW] = v;
    link_set[s][i % SHW] = 1'b1;
  endfunction

  function automatic bit fit_search(input int unsigned s, input int unsigned nw,
                                    output int unsigned cur_o, output int unsigned nxt_o);
    int unsigned cur, loops, steps, v, nxt, nv, mg, sp, e;
    cur = fit_start[s] % SHW;
    loops = 0;
    cur_o = 0;
    nxt_o = 0;
    for (steps = 0; steps < nfba_pkg::WALK_LIMIT; steps++) begin
      v = link_mem[s][cur];
      if (v[0] == 1'b0) begin
        nxt = v >> 1;
        mg = 0;
        while (mg < SHW && link_mem[s][nxt % SHW][0] == 1'b0) begin
          link_mem[s][cur] = link_mem[s][nxt % SHW];
          nxt = link_mem[s][cur] >> 1;
          mg++;
        end
        sp = fit_start[s];
        e = link_mem[s][cur] >> 1;
        if (cur < sp && sp < e) fit_start[s] = cur;
      end else begin
        nxt = cur;
      end
      if (nxt >= cur + nw) begin
        cur_o = cur;
        nxt_o = nxt;
        return 1'b1;
      end
      nv = link_mem[s][nxt % SHW];
      if (nxt > (nv >> 1)) begin
        loops++;
        if (loops > 1) return 1'b0;
      end
      cur = (nv >> 1) % SHW;
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_alloc(logic func, int unsigned cnt,
                                                  int unsigned sl, int unsigned off);
    alloc_result_t r;
    longint unsigned m64, w64;
    int unsigned m, nw, k, s, cur, nxt, sp, pos, ctl, v, tgt, credit, c;
    bit found, in_chain;
    r = '0;
    m64 = heap_words();
    if (m64 > SHW) begin
      r.st = nfba_pkg::ST_BAD_CFG;
      return r;
    end
    m = 32'(m64);
    if (func == nfba_pkg::FUNC_ALLOC) begin
      w64 = 1 + (longint'(cnt) * elem_bytes_r + WB - 1) / WB;
      if (w64 > m - 1) begin
        r.st = nfba_pkg::ST_TOO_LARGE;
        return r;
      end
      nw = 32'(w64);
      found = 1'b0;
      s = 0;
      cur = 0;
      nxt = 0;
      for (k = 0; k < chain_len && k < NS && !found; k++) begin
        s = slot_chain[k] % NS;
        if (free_words[s] >= nw) found = fit_search(s, nw, cur, nxt);
      end
      if (!found) begin
        for (s = 0; s < NS; s++)
          if (!slot_on[s]) break;
        if (s >= NS || chain_len >= NS) begin
          r.st = nfba_pkg::ST_NO_SLOT;
          return r;
        end
        slot_on[s] = 1'b1;
        slot_chain[chain_len] = s;
        chain_len++;
        free_words[s] = m - 1;
        link_wr(s, 0, (m - 1) << 1);
        link_wr(s, m - 1, 1);
        cur = 0;
        nxt = m - 1;
      end
      sp = cur + nw;
      fit_start[s] = sp % SHW;
      if (nxt > sp) link_wr(s, sp, link_mem[s][cur]);
      link_wr(s, cur, (sp << 1) | 1);
      free_words[s] -= nw;
      r.st = nfba_pkg::ST_OK;
      r.sh = nfba_pkg::FSLOT_W'(s);
      r.off = nfba_pkg::OFF_W'(cur + 1);
      return r;
    end
    if (off == 0 || sl >= NS || !slot_on[sl] || off >= m) begin
      r.st = nfba_pkg::ST_BAD_FREE;
      return r;
    end
    in_chain = 1'b0;
    pos = 0;
    for (k = 0; k < chain_len && k < NS; k++)
      if (slot_chain[k] == sl) begin
        in_chain = 1'b1;
        pos = k;
        break;
      end
    if (!in_chain) begin
      r.st = nfba_pkg::ST_BAD_FREE;
      return r;
    end
    ctl = off - 1;
    fit_start[sl] = ctl;
    v = link_mem[sl][ctl] & ~32'd1;
    link_mem[sl][ctl] = v;
    tgt = v >> 1;
    credit = (tgt > ctl) ? tgt - ctl : 0;
    c = free_words[sl] + credit;
    if (c > m - 1) c = m - 1;
    free_words[sl] = c;
    if (pos != 0 && c == m - 1) begin
      for (k = pos; k + 1 < chain_len && k + 1 < NS; k++)
        slot_chain[k] = slot_chain[k + 1];
      chain_len--;
      slot_chain[chain_len % NS] = 0;
      slot_on[sl] = 1'b0;
    end
    r.st = nfba_pkg::ST_OK;
    return r;
  endfunction

  task automatic send_word(logic func, int unsigned cnt, int unsigned sl, int unsigned off);
    alloc_result_t r;
    bit rdy;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {4'b0, off[nfba_pkg::OFF_W-1:0], sl[nfba_pkg::FSLOT_W-1:0],
                 cnt[nfba_pkg::CNT_W-1:0]};
    forever begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
      if (rdy) break;
    end
    r = predict_alloc(func, cnt, sl, off);
    result_q.push_back(r);
    if (func == nfba_pkg::FUNC_ALLOC && r.st == nfba_pkg::ST_OK) live_q.push_back({r.off, r.sh});
    burst_left--;
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    bit rdy;
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (result_q.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[nfba_pkg::CFG_DATA_W-1:0];
    forever begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
      if (rdy) break;
    end
    cfg_valid <= 1'b0;
    if (idx == nfba_pkg::CFG_EB) elem_bytes_r = val & 32'h1FFF;
    else elem_per_heap_r = val & 32'hFFFF;
  endtask

  task automatic send_random();
    longint unsigned m64;
    int unsigned maxcnt, cnt, sl, off, i;
    m64 = heap_words();
    if ($urandom_range(0, 99) < 55) begin
      cnt = $urandom_range(0, 65535);
      if (m64 <= SHW && $urandom_range(0, 19) != 0) begin
        maxcnt = 32'(((m64 - 2) * WB) / elem_bytes_r);
        if (maxcnt > 65535) maxcnt = 65535;
        cnt = $urandom_range(0, (maxcnt / 4 > 0) ? maxcnt / 4 : maxcnt);
        if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, maxcnt);
      end
      send_word(nfba_pkg::FUNC_ALLOC, cnt, $urandom_range(0, 3), $urandom_range(0, 1023));
      return;
    end
    if (live_q.size() > 0 && $urandom_range(0, 99) < 85) begin
      i = $urandom_range(0, live_q.size() - 1);
      sl = live_q[i][1:0];
      off = live_q[i][11:2];
      if ($urandom_range(0, 19) != 0) live_q.delete(i);
    end else begin
      sl = $urandom_range(0, 3);
      off = $urandom_range(0, 1023);
      // never touch a link word that was never written
      if (off != 0 && !link_set[sl][off - 1]) off = 0;
    end
    send_word(FUNC_FREE, $urandom_range(0, 65535), sl, off);
  endtask

  task automatic test_directed();
    int unsigned s;
    send_word(nfba_pkg::FUNC_ALLOC, 0, 0, 0);
    send_word(nfba_pkg::FUNC_ALLOC, 16'hFFFF, 3, 1023);
    send_word(nfba_pkg::FUNC_ALLOC, 1000, 0, 0);
    send_word(FUNC_FREE, 0, 1, 1);
    send_word(FUNC_FREE, 0, 1, 1);
    send_word(FUNC_FREE, 0, 0, 0);
    send_word(FUNC_FREE, 0, 0, 1023);
    send_word(FUNC_FREE, 0, 3, 5);
    send_word(FUNC_FREE, 0, 0, 1);
    send_word(FUNC_FREE, 0, 0, 1);
    repeat (5) send_word(nfba_pkg::FUNC_ALLOC, 1000, 0, 0);
    for (s = 1; s < NS; s++) send_word(FUNC_FREE, 0, s, 1);
    send_word(FUNC_FREE, 0, 0, 1);
    live_q.delete();
  endtask

  task automatic test_random(int n);
    repeat (n) send_random();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_random();
  endtask

  task automatic test_geometry(int unsigned eb, int unsigned eps, int n);
    write_reg(nfba_pkg::CFG_EB, eb);
    write_reg(nfba_pkg::CFG_EPS, eps);
    test_random(n);
  endtask

  // result checker and receiver stall pattern
  initial begin
    alloc_result_t e;
    logic v, r;
    logic [nfba_pkg::OUT_DATA_W-1:0] d;
    logic [nfba_pkg::ST_W-1:0] u;
    int unsigned cyc, hold_left;
    cyc = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      v = out_tvalid;
      r = out_tready;
      d = out_tdata;
      u = out_tuser;
      @(posedge clk);
      if (rst_n && v && r) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected word status=%0d data=%h", $time, u, d);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (u !== e.st || d !== {4'b0, e.off, e.sh}) begin
            $display("%0t: mismatch expected st=%0d sh=%0d off=%0d actual st=%0d data=%h",
                     $time, e.st, e.sh, e.off, u, d);
            errors++;
          end
        end
      end
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((cyc / 300) % 3)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          default: out_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(350);
    test_backpressure();
    test_geometry(1, 1, 150);
    test_geometry(4096, 1, 200);
    test_geometry(8, 60, 350);
    test_geometry(4096, 65535, 30);
    test_geometry(1, 65535, 20);
    test_geometry(8, 1000, 350);
    in_tvalid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/nfba_pkg.sv
rtl/nfba_dp.sv
rtl/nfba_ctrl.sv
rtl/next_fit_block_allocator.sv
sim/tb_next_fit_block_allocator.sv
